### rtl/wnc_pkg.sv
// shared types and constants for the window normalized correlation block
package wnc_pkg;

  localparam int unsigned MaxWindowDef  = 256;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned InSampleW     = 16;
  localparam int unsigned CorrW         = 17;
  localparam int unsigned FracW         = 16;
  localparam logic [CorrW-1:0] OneQ16   = 17'h10000;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // store the input word and update sums
    logic clr;        // clear window state
    logic rd;         // issue store read at scan index
    logic dev;        // form deviations from read data
    logic div_start;  // start the shared divider
    logic acc;        // add finished term to accumulator
    logic fin_start;  // select the final mean operands for the divider
    logic fin_done;   // capture the clamped mean
  } wnc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;       // window holds the maximum pair count
    logic empty;      // no pairs stored
    logic scan_end;   // scan index reached the pair count
    logic div_busy;   // divider still working
    logic acc_pos;    // term sum greater than zero
  } wnc_sts_t;

endpackage

### rtl/wnc_datapath.sv
// sample stores, running sums, shared restoring divider and term accumulator
module wnc_datapath #(
  parameter int unsigned MAX_WINDOW  = wnc_pkg::MaxWindowDef,
  parameter int unsigned SAMPLE_BITS = wnc_pkg::SampleBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wnc_pkg::wnc_cmd_t                cmd,
  output wnc_pkg::wnc_sts_t                sts,
  input  logic [wnc_pkg::InSampleW-1:0]    in_src,
  input  logic [wnc_pkg::InSampleW-1:0]    in_comp,
  output logic [wnc_pkg::CorrW-1:0]        corr
);
  import wnc_pkg::*;

  localparam int unsigned AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUMW = SAMPLE_BITS + CW;
  // deviation magnitude fits n*sample
  localparam int unsigned MAGW = SAMPLE_BITS + CW;
  localparam int unsigned DVW  = MAGW + FracW;
  localparam int unsigned ACCW = FracW + 2 + CW;
  localparam int unsigned DCW  = $clog2(DVW + 1);

  logic [SAMPLE_BITS-1:0] src_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] comp_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] src_rd_r, comp_rd_r;

  logic [SUMW-1:0] sum_src_r, sum_comp_r;
  logic [CW-1:0]   cnt_r, idx_r;
  logic [AW-1:0]   wr_addr, rd_addr;

  logic [MAGW:0]   d1_r, d2_r;      // signed deviations
  logic [DVW-1:0]  quo_r;           // dividend shifting into quotient
  logic [MAGW:0]   rem_r;
  logic [DVW-1:0]  dvs_r;
  logic [DCW-1:0]  dcnt_r;
  logic            neg_r, one_r;
  logic [ACCW-1:0] acc_r;

  assign wr_addr = cnt_r[AW-1:0];
  assign rd_addr = idx_r[AW-1:0];

  // sample stores
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_mem[wr_addr]  <= in_src[SAMPLE_BITS-1:0];
      comp_mem[wr_addr] <= in_comp[SAMPLE_BITS-1:0];
    end
    if (cmd.rd) begin
      src_rd_r  <= src_mem[rd_addr];
      comp_rd_r <= comp_mem[rd_addr];
    end
  end

  // sums, count and scan index
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      sum_src_r  <= '0;
      sum_comp_r <= '0;
      cnt_r      <= '0;
      idx_r      <= '0;
    end else begin
      if (cmd.load) begin
        sum_src_r  <= sum_src_r + SUMW'(in_src[SAMPLE_BITS-1:0]);
        sum_comp_r <= sum_comp_r + SUMW'(in_comp[SAMPLE_BITS-1:0]);
        cnt_r      <= cnt_r + 1'b1;
      end
      if (cmd.rd) idx_r <= idx_r + 1'b1;
    end
  end

  // deviations n*sample - sum
  logic [MAGW:0] d1_nxt, d2_nxt;
  logic [MAGW-1:0] a1, a2;
  assign d1_nxt = (MAGW+1)'(cnt_r) * (MAGW+1)'(src_rd_r) - (MAGW+1)'(sum_src_r);
  assign d2_nxt = (MAGW+1)'(cnt_r) * (MAGW+1)'(comp_rd_r) - (MAGW+1)'(sum_comp_r);
  assign a1 = d1_r[MAGW] ? MAGW'(-d1_r) : d1_r[MAGW-1:0];
  assign a2 = d2_r[MAGW] ? MAGW'(-d2_r) : d2_r[MAGW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.dev) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  // shared restoring divider, one quotient bit a cycle
  logic [MAGW:0] trial;
  assign trial = {rem_r[MAGW-1:0], quo_r[DVW-1]} - (MAGW+1)'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      rem_r  <= '0;
      dcnt_r <= DCW'(DVW);
      if (cmd.fin_start) begin
        quo_r <= DVW'(acc_r);
        dvs_r <= DVW'(cnt_r);
      end else begin
        quo_r  <= {((a1 > a2) ? a2 : a1), FracW'(0)};
        dvs_r  <= DVW'((a1 > a2) ? a1 : a2);
        neg_r  <= d1_r[MAGW] ^ d2_r[MAGW];
        one_r  <= (a1 == '0) && (a2 == '0);
      end
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (!trial[MAGW]) begin
        rem_r <= trial;
        quo_r <= {quo_r[DVW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[MAGW-1:0], quo_r[DVW-1]};
        quo_r <= {quo_r[DVW-2:0], 1'b0};
      end
    end
  end

  // term accumulator
  logic [ACCW-1:0] term;
  always_comb begin
    if (one_r) term = ACCW'(OneQ16);
    else if (neg_r) term = -ACCW'(quo_r[FracW:0]);
    else term = ACCW'(quo_r[FracW:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) acc_r <= '0;
    else if (cmd.acc) acc_r <= acc_r + term;
  end

  // clamped mean
  always_ff @(posedge clk) begin
    if (cmd.fin_done) begin
      if (!sts.acc_pos || sts.empty) corr <= '0;
      else if (quo_r > DVW'(OneQ16)) corr <= OneQ16;
      else corr <= quo_r[CorrW-1:0];
    end
  end

  assign sts.full     = (cnt_r == CW'(MAX_WINDOW));
  assign sts.empty    = (cnt_r == '0);
  assign sts.scan_end = (idx_r == cnt_r);
  assign sts.div_busy = (dcnt_r != '0);
  assign sts.acc_pos  = !acc_r[ACCW-1] && (acc_r != '0);
endmodule

### rtl/wnc_ctrl.sv
// controller sequencing load, scan, per-pair divide and final mean
module wnc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_last,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_ovf,
  output wnc_pkg::wnc_cmd_t cmd,
  input  wnc_pkg::wnc_sts_t sts
);
  import wnc_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_DEV  = 8'b0000_0100,
    S_DIVS = 8'b0000_1000,
    S_DIVW = 8'b0001_0000,
    S_FIN  = 8'b0010_0000,
    S_FINW = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovf_r, ovf_nxt;
  logic   acc_pend_r;
  logic   in_acc;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign out_ovf    = ovf_r;
  assign in_acc     = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (sts.full) ovf_nxt = 1'b1;
          else cmd.load = 1'b1;
          if (in_last) state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (acc_pend_r) cmd.acc = 1'b1;
        if (sts.scan_end) state_nxt = S_FIN;
        else begin
          cmd.rd    = 1'b1;
          state_nxt = S_DEV;
        end
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.div_busy) state_nxt = S_RD;
      end
      S_FIN: begin
        cmd.div_start = 1'b1;
        cmd.fin_start = 1'b1;
        state_nxt     = S_FINW;
      end
      S_FINW: begin
        if (!sts.div_busy) begin
          cmd.fin_done = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          cmd.clr   = 1'b1;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      ovf_r      <= 1'b0;
      acc_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ovf_r      <= ovf_nxt;
      acc_pend_r <= (state_r == S_DIVW) && !sts.div_busy;
    end
  end
endmodule

### rtl/window_normalized_correlation.sv
// top level of the window normalized correlation block
// Pairs load at one per cycle while the block accepts input; after the last
// pair each stored pair is read, its deviations formed and its term divided in
// the shared one-bit-per-cycle divider, plus one final divide for the mean; one
// window is processed at a time and input is held off until the result is taken.
module window_normalized_correlation #(
  parameter int unsigned MAX_WINDOW  = wnc_pkg::MaxWindowDef,
  parameter int unsigned SAMPLE_BITS = wnc_pkg::SampleBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_src [15:0], sample_comp [31:16]
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // correlation [16:0], overflow [17], zero fill
  output logic        out_tlast
);
  import wnc_pkg::*;

  wnc_cmd_t         cmd;
  wnc_sts_t         sts;
  logic [CorrW-1:0] corr;
  logic             ovf;

  wnc_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_last(in_tlast),
    .out_tvalid, .out_tready, .out_ovf(ovf), .cmd, .sts
  );

  wnc_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_src(in_tdata[15:0]), .in_comp(in_tdata[31:16]), .corr
  );

  assign out_tdata = {6'd0, ovf, corr};
  assign out_tlast = 1'b1;
endmodule

### rtl/wnc_checker.sv
// port-level checks for the window normalized correlation block
module wnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  // result never above one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] <= 17'h10000) else $error("corr above one");
  // no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during output");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
endmodule

bind window_normalized_correlation wnc_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
